// ===== src/assert_macros.svh =====
// Assertion macros shared by the page table lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_DIS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_DIS(label, clk, rst, prop)

`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== src/ptlr_pkg.sv =====
// Package with constants and command types for the page table lookup block.
`timescale 1ns / 1ps
package ptlr_pkg;

  localparam int ENTRIES   = 16;
  localparam int ADDR_BITS = 32;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int N_W     = $clog2(ENTRIES + 1);
  localparam int CNT_W   = $clog2(ADDR_BITS + 1);
  localparam int VA_W    = 32;
  localparam int PS_W    = 17;
  localparam int EIU_W   = 5;
  localparam int FRAME_W = 4;
  localparam int PHYS_W  = 20;
  localparam int PHYS_FULL_W = FRAME_W + PS_W + 1;
  localparam int OUT_W   = 1 + FRAME_W + PHYS_W;
  localparam int TDATA_W = 32;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_PG_BYTES = 2'd0;
  localparam logic [1:0] REG_ENTRIES  = 2'd1;
  localparam logic [1:0] REG_LRU_MODE = 2'd2;

  localparam logic [PS_W-1:0]  PG_BYTES_RST = PS_W'(4096);
  localparam logic [EIU_W-1:0] ENTRIES_RST  = EIU_W'(16);

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic start;
    logic search;
    logic decide;
    logic update;
    logic load_out;
  } ptlr_cmd_t;

  typedef struct packed {
    logic div_done;
  } ptlr_stat_t;

endpackage

// ===== src/ptlr_div.sv =====
// Restoring divider that yields page number and page offset, one bit per cycle.
`timescale 1ns / 1ps
module ptlr_div import ptlr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ADDR_BITS-1:0] dividend,
  input  logic [PS_W-1:0]      divisor,
  output logic                 done,
  output logic [ADDR_BITS-1:0] quotient,
  output logic [PS_W-1:0]      remainder
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [PS_W:0]    trial;
  logic [PS_W:0]    diff;

  assign trial = {remainder, quotient[ADDR_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign done  = busy && (cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(ADDR_BITS);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        remainder <= diff[PS_W-1:0];
        quotient  <= {quotient[ADDR_BITS-2:0], 1'b1};
      end else begin
        remainder <= trial[PS_W-1:0];
        quotient  <= {quotient[ADDR_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/ptlr_dp.sv =====
// Datapath: divider, associative page table, replacement update and result registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptlr_dp import ptlr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ptlr_cmd_t          cmd,
  output ptlr_stat_t         stat,
  input  logic [VA_W-1:0]    virtual_address,
  input  logic [PS_W-1:0]    divisor,
  input  logic [EIU_W-1:0]   entries_in_use,
  input  logic               lru_mode,
  output logic               out_fault,
  output logic [FRAME_W-1:0] out_frame,
  output logic [PHYS_W-1:0]  out_phys
);

  logic [ADDR_BITS-1:0] entry_page  [ENTRIES];
  logic [FRAME_W-1:0]   entry_frame [ENTRIES];
  logic [ENTRIES-1:0]   entry_valid;

  logic [ADDR_BITS-1:0] page;
  logic [PS_W-1:0]      offset;
  logic [N_W-1:0]       n;

  logic [ENTRIES-1:0] match_v;
  logic [ENTRIES-1:0] empty_v;
  logic [ENTRIES-1:0] brk_v;
  logic [ENTRIES-1:0] match_next;
  logic [ENTRIES-1:0] empty_next;
  logic [ENTRIES-1:0] brk_next;

  idx_t               hit_idx;
  idx_t               empty_idx;
  idx_t               last_idx;
  idx_t               lo;
  idx_t               hi;
  idx_t               lo_next;
  idx_t               hi_next;
  logic [FRAME_W-1:0] frame_sel;
  logic [FRAME_W-1:0] frame_sel_next;
  logic               fault;
  logic               fault_next;

  logic [PHYS_FULL_W-1:0] phys_full;
  logic                   res_fault;
  logic [FRAME_W-1:0]     res_frame;
  logic [PHYS_W-1:0]      res_phys;

  ptlr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start),
    .dividend  (virtual_address[ADDR_BITS-1:0]),
    .divisor   (divisor),
    .done      (stat.div_done),
    .quotient  (page),
    .remainder (offset)
  );

  always_comb begin
    if (entries_in_use == '0) begin
      n = N_W'(1);
    end else if (32'(entries_in_use) > ENTRIES) begin
      n = N_W'(ENTRIES);
    end else begin
      n = N_W'(entries_in_use);
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_next[i] = (N_W'(i) < n) && entry_valid[i] && (entry_page[i] == page);
      empty_next[i] = (N_W'(i) < n) && !entry_valid[i];
      brk_next[i]   = (N_W'(i) >= n) || !entry_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      match_v <= match_next;
      empty_v <= empty_next;
      brk_v   <= brk_next;
    end
  end

  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_v[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (empty_v[i]) begin
        empty_idx = IDX_W'(i);
      end
    end
    last_idx = IDX_W'(ENTRIES - 1);
    for (int j = ENTRIES - 1; j >= 1; j--) begin
      if ((IDX_W'(j) > hit_idx) && brk_v[j]) begin
        last_idx = IDX_W'(j - 1);
      end
    end
  end

  always_comb begin
    priority if (|match_v) begin
      lo_next        = hit_idx;
      hi_next        = lru_mode ? last_idx : hit_idx;
      frame_sel_next = entry_frame[hit_idx];
      fault_next     = 1'b0;
    end else if (|empty_v) begin
      lo_next        = empty_idx;
      hi_next        = empty_idx;
      frame_sel_next = FRAME_W'(empty_idx);
      fault_next     = 1'b1;
    end else begin
      lo_next        = '0;
      hi_next        = IDX_W'(n - N_W'(1));
      frame_sel_next = entry_frame[0];
      fault_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      lo        <= lo_next;
      hi        <= hi_next;
      frame_sel <= frame_sel_next;
      fault     <= fault_next;
    end
  end

  // Entries in [lo, hi) move one place toward the head; the word lands at hi.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if ((IDX_W'(i) >= lo) && (IDX_W'(i) < hi)) begin
          entry_page[i]  <= entry_page[(i + 1) % ENTRIES];
          entry_frame[i] <= entry_frame[(i + 1) % ENTRIES];
        end else if (IDX_W'(i) == hi) begin
          entry_page[i]  <= page;
          entry_frame[i] <= frame_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if ((IDX_W'(i) >= lo) && (IDX_W'(i) <= hi)) begin
          entry_valid[i] <= 1'b1;
        end
      end
    end
  end

  assign phys_full = PHYS_FULL_W'(frame_sel) * PHYS_FULL_W'(divisor) + PHYS_FULL_W'(offset);

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_fault <= fault;
      res_frame <= frame_sel;
      res_phys  <= fault ? '0 : phys_full[PHYS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_fault <= res_fault;
      out_frame <= res_frame;
      out_phys  <= res_phys;
    end
  end

  `ASSERT_DIS(a_slot_filled, clk, rst, cmd.update |=> entry_valid[hi])

endmodule

// ===== src/ptlr_ctrl.sv =====
// Controller state machine that sequences division, search, update and output.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptlr_ctrl import ptlr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  ptlr_stat_t stat,
  output ptlr_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_DIS(a_load_room, clk, rst, cmd.load_out |-> (!out_valid || m_tready))
  `ASSERT_DIS(a_accept_div, clk, rst, (s_tvalid && s_tready) |=> (state == ST_DIV))
  `ASSERT_DIS(a_done_in_div, clk, rst, stat.div_done |-> (state == ST_DIV))

endmodule

// ===== src/page_table_lookup_replace.sv =====
// Top level of the page table lookup: configuration registers, controller and datapath.
//
// A virtual address word arrives on the s_ stream and is split into page number
// and offset by the configured page size. The page is looked up in a fully
// associative table and one result word leaves on the m_ stream: fault flag,
// frame number and physical address (zero on a fault). Misses fill the first
// empty slot or evict the head entry; with lru_mode set, hits move to the tail.
// Each word passes through the 32-step restoring divider and then the search,
// decide, update and output states; the next word is accepted only after the
// previous result has been loaded into the output register.
// A finished result waits in an output register, and the next word is already
// accepted and processed while the receiver stalls; only the final hand-off
// waits for the register to drain.
// Reset empties the table and loads a page size of 4096, 16 entries and FIFO mode.
// Configuration writes use the APB port at byte addresses 0, 4 and 8 and must be
// made only while no word is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
module page_table_lookup_replace import ptlr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [31:0] virtual_address
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [0] page_fault, [4:1] frame_number,
                                        // [24:5] physical_address, rest zero
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  logic [PS_W-1:0]    pg_bytes;
  logic [EIU_W-1:0]   entries_in_use;
  logic               lru_mode;
  logic [PS_W-1:0]    divisor;
  logic               cfg_wr;
  ptlr_cmd_t          cmd;
  ptlr_stat_t         stat;
  logic               out_fault;
  logic [FRAME_W-1:0] out_frame;
  logic [PHYS_W-1:0]  out_phys;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign divisor = (pg_bytes == '0) ? PS_W'(1) : pg_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      pg_bytes       <= PG_BYTES_RST;
      entries_in_use <= ENTRIES_RST;
      lru_mode       <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PG_BYTES: pg_bytes       <= pwdata[PS_W-1:0];
        REG_ENTRIES:  entries_in_use <= pwdata[EIU_W-1:0];
        REG_LRU_MODE: lru_mode       <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PG_BYTES: prdata = CFG_DW'(pg_bytes);
      REG_ENTRIES:  prdata = CFG_DW'(entries_in_use);
      REG_LRU_MODE: prdata = CFG_DW'(lru_mode);
      default:      prdata = '0;
    endcase
  end

  ptlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptlr_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .virtual_address (s_tdata[VA_W-1:0]),
    .divisor         (divisor),
    .entries_in_use  (entries_in_use),
    .lru_mode        (lru_mode),
    .out_fault       (out_fault),
    .out_frame       (out_frame),
    .out_phys        (out_phys)
  );

  assign m_tdata = {{(TDATA_W - OUT_W){1'b0}}, out_phys, out_frame, out_fault};

endmodule

// ===== test/tb_page_table_lookup_replace.sv =====
// Self-checking testbench for the page table lookup block with FIFO and LRU replacement.
`timescale 1ns / 1ps
module tb_page_table_lookup_replace import ptlr_pkg::*; ();

  typedef struct {
    logic        fault;
    logic [3:0]  frame;
    logic [19:0] phys;
  } xlate_t;

  class page_table_book;
    logic [16:0]       pg_size;
    logic [4:0]        slot_count_reg;
    logic              lru_on;
    logic [31:0]       slot_page [ENTRIES];
    logic [3:0]        slot_frame [ENTRIES];
    logic              slot_valid [ENTRIES];
    xlate_t            expected_xlates [$];
    int                mismatches;
    int                hits_seen;
    int                faults_seen;
    int                words_checked;

    function new();
      pg_size = 17'd4096;
      slot_count_reg = 5'd16;
      lru_on = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
      end
      mismatches = 0;
      hits_seen = 0;
      faults_seen = 0;
      words_checked = 0;
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
      end
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_PG_BYTES: pg_size = value[16:0];
        REG_ENTRIES:  slot_count_reg = value[4:0];
        REG_LRU_MODE: lru_on = value[0];
        default: ;
      endcase
    endfunction

    function void check_register(logic [1:0] idx, logic [31:0] got);
      logic [31:0] want;
      case (idx)
        REG_PG_BYTES: want = {15'd0, pg_size};
        REG_ENTRIES:  want = {27'd0, slot_count_reg};
        default:      want = {31'd0, lru_on};
      endcase
      if (got !== want) report("register readback", want, got);
    endfunction

    // Slides slots first+1..last one place toward the head and puts the page at last.
    function void move_to_tail(int unsigned first, int unsigned last,
                               logic [31:0] page, logic [3:0] frame);
      for (int unsigned i = first; i < last; i++) begin
        slot_page[i] = slot_page[i + 1];
        slot_frame[i] = slot_frame[i + 1];
        slot_valid[i] = slot_valid[i + 1];
      end
      slot_page[last] = page;
      slot_frame[last] = frame;
      slot_valid[last] = 1'b1;
    endfunction

    function void note_address(logic [31:0] va);
      int unsigned ps;
      int unsigned page;
      int unsigned offset;
      int unsigned n;
      int unsigned hit;
      int unsigned empty;
      int unsigned last;
      int unsigned frame;
      int unsigned phys_full;
      xlate_t x;
      ps = (pg_size == 0) ? 1 : pg_size;
      page = va / ps;
      offset = va % ps;
      n = (slot_count_reg == 0) ? 1 : ((slot_count_reg > ENTRIES) ? ENTRIES : slot_count_reg);
      hit = n;
      empty = n;
      for (int unsigned i = 0; i < n; i++) begin
        if (slot_valid[i] && slot_page[i] == page) begin
          hit = i;
          break;
        end
        if (!slot_valid[i] && empty == n) empty = i;
      end
      if (hit < n) begin
        frame = slot_frame[hit];
        if (lru_on) begin
          last = hit;
          while (last + 1 < n && slot_valid[last + 1]) last++;
          move_to_tail(hit, last, page, frame[3:0]);
        end
        phys_full = frame * ps + offset;
        x.fault = 1'b0;
        x.frame = frame[3:0];
        x.phys = phys_full[19:0];
      end else if (empty < n) begin
        slot_page[empty] = page;
        slot_frame[empty] = empty[3:0];
        slot_valid[empty] = 1'b1;
        x.fault = 1'b1;
        x.frame = empty[3:0];
        x.phys = 20'd0;
      end else begin
        frame = slot_frame[0];
        move_to_tail(0, n - 1, page, frame[3:0]);
        x.fault = 1'b1;
        x.frame = frame[3:0];
        x.phys = 20'd0;
      end
      expected_xlates.push_back(x);
    endfunction

    function void check_result(logic [31:0] word);
      xlate_t want;
      if (expected_xlates.size() == 0) begin
        report("unexpected result word", 0, word);
      end else begin
        want = expected_xlates.pop_front();
        words_checked++;
        if (want.fault) faults_seen++;
        else hits_seen++;
        if (word[0] !== want.fault) report("page_fault", want.fault, word[0]);
        if (word[4:1] !== want.frame) report("frame_number", want.frame, word[4:1]);
        if (word[24:5] !== want.phys) report("physical_address", want.phys, word[24:5]);
      end
    endfunction

    function int pending();
      return expected_xlates.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;   // [31:0] virtual_address
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;   // [0] page_fault, [4:1] frame_number, [24:5] physical_address
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [CFG_DW-1:0]  pwdata;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  page_table_book book = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned holds_requested;
  int unsigned holds_served;
  int unsigned hold_left;
  int          settings_run;

  page_table_lookup_replace u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // The receiver decides its ready at each falling edge and counts down any hold-off itself.
  initial begin
    m_tready = 1'b0;
    holds_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_requested) begin
        holds_served = holds_requested;
        hold_left = 400;
      end
      if (rst) begin
        m_tready = 1'b0;
      end else if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_result(m_tdata);
  end

  task automatic send_word(input logic [31:0] va);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = va;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_address(va);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    book.set_register(idx, value);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    book.check_register(idx, prdata);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic run_setting(input int unsigned ps_val, input int unsigned n_val,
                             input int unsigned lru_val, input int words);
    int unsigned     ps;
    int unsigned     n;
    int unsigned     top_page;
    int unsigned     pool [$];
    longint unsigned addr;
    write_reg(REG_PG_BYTES, ps_val);
    write_reg(REG_ENTRIES, n_val);
    write_reg(REG_LRU_MODE, lru_val);
    settings_run++;
    ps = (ps_val[16:0] == 0) ? 1 : ps_val[16:0];
    n = (n_val[4:0] == 0) ? 1 : ((n_val[4:0] > ENTRIES) ? ENTRIES : n_val[4:0]);
    top_page = 32'hFFFF_FFFF / ps;
    // A working set a little larger than the table gives a mix of hits and evictions.
    if ($urandom_range(1)) pool.push_back(top_page);
    if ($urandom_range(1)) pool.push_back(0);
    while (pool.size() < n + $urandom_range(1, 3)) pool.push_back($urandom_range(top_page));
    for (int k = 0; k < words; k++) begin
      if ($urandom_range(99) < 12) begin
        addr = $urandom;
      end else begin
        addr = longint'(pool[$urandom_range(pool.size() - 1)]) * ps + $urandom_range(ps - 1);
        if (addr > 64'hFFFF_FFFF) addr = 64'hFFFF_FFFF;
      end
      send_word(addr[31:0]);
    end
    wait_idle();
  endtask

  initial begin
    int unsigned cfg_ps [12]  = '{4096, 1, 65536, 131071, 0, 256, 16, 100, 7, 65536, 3, 512};
    int unsigned cfg_n [12]   = '{16, 4, 16, 3, 1, 8, 31, 5, 16, 12, 0, 2};
    int unsigned cfg_lru [12] = '{0, 1, 1, 0, 1, 0, 1, 0, 0, 0, 1, 1};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_requested = 0;
    settings_run = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (5) @(negedge clk);

    // Reset settings: empty table fills from slot zero, then hits at both ends of a page.
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0FFF);
    send_word(32'hFFFF_F000);
    send_word(32'h0000_1000);
    wait_idle();

    // Shrunken table under LRU: head eviction, a hit moved to the tail, then regrowth.
    write_reg(REG_ENTRIES, 32'd2);
    write_reg(REG_LRU_MODE, 32'd1);
    settings_run++;
    send_word(32'h0000_1000);
    send_word(32'hFFFF_F123);
    send_word(32'h0000_2000);
    send_word(32'hFFFF_F000);
    wait_idle();
    write_reg(REG_ENTRIES, 32'd16);
    settings_run++;
    send_word(32'h0000_1ABC);
    send_word(32'h0000_2FFF);
    wait_idle();

    // Zero page size and zero entry count act as one.
    write_reg(REG_PG_BYTES, 32'd0);
    write_reg(REG_ENTRIES, 32'd0);
    write_reg(REG_LRU_MODE, 32'd0);
    settings_run++;
    send_word(32'h0000_0005);
    send_word(32'h0000_0005);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    wait_idle();

    // Pages of 65536 bytes with an oversized count; frame times page size plus offset still fits the field.
    write_reg(REG_PG_BYTES, 32'd65536);
    write_reg(REG_ENTRIES, 32'd31);
    write_reg(REG_LRU_MODE, 32'd1);
    settings_run++;
    for (int k = 0; k < 18; k++) send_word({k[15:0] ^ 16'hFFF0, 16'h8000 | k[15:0]});
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFE_1234);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 19;
        recv_idle_pct = 55;
      end else if (p < 8) begin
        send_idle_pct = 55;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 9) holds_requested++;
      run_setting(cfg_ps[p], cfg_n[p], cfg_lru[p], 68);
    end

    $display("Translated %0d addresses: %0d hits and %0d page faults over %0d register settings.",
             book.words_checked, book.hits_seen, book.faults_seen, settings_run);
    $display("Traffic ran with sender and receiver gaps both ways, none, and a long output stall.");
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
